[hw/rtl/srecord_line_parser_core_assert.svh]
// ----------------------------------------------------------------------------
// S-record line parser assertion macros
// Shared concurrent assertion forms, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef SRECORD_LINE_PARSER_CORE_ASSERT_SVH
`define SRECORD_LINE_PARSER_CORE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define SRLP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition must never be true outside reset.
`define SRLP_ASSERT_NEVER(label, cond, msg) \
	`SRLP_ASSERT(label, !(cond), msg)

`endif

[hw/rtl/srlp_pkg.sv]
// ----------------------------------------------------------------------------
// S-record line parser package
// Item types, result codes and character decode helpers.
// ----------------------------------------------------------------------------
package srlp_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] byte_address;
		logic [7:0]  data_byte;
		logic [1:0]  line_status;
	} out_item_t;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_NA  = 2'd1;
	localparam logic [1:0] STATUS_BAD = 2'd2;

	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] SUM_GOOD  = 8'hFF;
	localparam logic [8:0] INDEX_MAX = 9'd511;
	localparam logic [9:0] POS_MAX   = 10'd1023;
	localparam logic [9:0] POS_WRAP  = 10'd2;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nib = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.nib = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [2:0] addr_len(input logic [7:0] rtype);
		logic [2:0] n;
		case (rtype)
			8'h31:   n = 3'd2;
			8'h32:   n = 3'd3;
			8'h33:   n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

[hw/rtl/srlp_parse.sv]
// ----------------------------------------------------------------------------
// S-record line parser step logic
// Holds the line state and turns one item into at most one result.
// ----------------------------------------------------------------------------
module srlp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  srlp_pkg::in_item_t  item,
	output logic                has_result,
	output srlp_pkg::out_item_t result
);

	logic [9:0]  pos_q;
	logic [7:0]  rtype_q;
	logic [7:0]  count_q;
	logic [8:0]  index_q;
	logic [7:0]  sum_q;
	logic [31:0] base_q;
	logic [3:0]  high_q;
	logic        err_q;

	logic [9:0]  pos_d;
	logic [7:0]  rtype_d;
	logic [7:0]  count_d;
	logic [8:0]  index_d;
	logic [7:0]  sum_d;
	logic [31:0] base_d;
	logic [3:0]  high_d;
	logic        err_d;

	srlp_pkg::hex_t h;
	logic [2:0]  alen;
	logic [7:0]  b;
	logic [8:0]  off;
	logic        bad;

	always_comb begin
		h     = srlp_pkg::hex_value(item.character);
		alen  = srlp_pkg::addr_len(rtype_q);
		b     = {high_q, h.nib};
		off   = index_q - {6'd0, alen} - 9'd1;
		pos_d   = pos_q;
		rtype_d = rtype_q;
		count_d = count_q;
		index_d = index_q;
		sum_d   = sum_q;
		base_d  = base_q;
		high_d  = high_q;
		err_d   = err_q;
		has_result = 1'b0;
		result     = '0;
		bad = err_q || (pos_q < 10'd4) || pos_q[0]
			|| (index_q != ({1'b0, count_q} + 9'd1)) || (sum_q != srlp_pkg::SUM_GOOD)
			|| ((alen != 3'd0) && ({1'b0, count_q} < ({6'd0, alen} + 9'd1)));
		if (item.line_end) begin
			has_result = 1'b1;
			result.result_kind = srlp_pkg::KIND_STATUS;
			if (bad) begin
				result.line_status = srlp_pkg::STATUS_BAD;
			end else if (alen == 3'd0) begin
				result.line_status = srlp_pkg::STATUS_NA;
			end else begin
				result.line_status = srlp_pkg::STATUS_OK;
			end
			pos_d   = '0;
			rtype_d = '0;
			count_d = '0;
			index_d = '0;
			sum_d   = '0;
			base_d  = '0;
			high_d  = '0;
			err_d   = 1'b0;
		end else begin
			if (pos_q == 10'd0) begin
				if (item.character != srlp_pkg::CHAR_S) begin
					err_d = 1'b1;
				end
			end else if (pos_q == 10'd1) begin
				if (item.character < 8'h30 || item.character > 8'h39) begin
					err_d = 1'b1;
				end
				rtype_d = item.character;
			end else begin
				if (!h.ok) begin
					err_d = 1'b1;
				end
				if (!pos_q[0]) begin
					high_d = h.nib;
				end else begin
					if (index_q == 9'd0) begin
						count_d = b;
					end else if (index_q > {1'b0, count_q}) begin
						err_d = 1'b1;
					end
					sum_d = sum_q + b;
					if (index_q >= 9'd1 && index_q <= {6'd0, alen}) begin
						base_d = {base_q[23:0], b};
					end
					if (alen != 3'd0 && index_q > {6'd0, alen}
						&& index_q < {1'b0, count_q} && !err_d) begin
						has_result = 1'b1;
						result.result_kind  = srlp_pkg::KIND_DATA;
						result.byte_address = base_q + {23'd0, off};
						result.data_byte    = b;
						result.line_status  = srlp_pkg::STATUS_OK;
					end
					index_d = (index_q < srlp_pkg::INDEX_MAX) ? index_q + 9'd1
						: srlp_pkg::INDEX_MAX;
				end
			end
			pos_d = (pos_q >= srlp_pkg::POS_MAX) ? srlp_pkg::POS_WRAP : pos_q + 10'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			rtype_q <= '0;
			count_q <= '0;
			index_q <= '0;
			sum_q   <= '0;
			base_q  <= '0;
			high_q  <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			pos_q   <= pos_d;
			rtype_q <= rtype_d;
			count_q <= count_d;
			index_q <= index_d;
			sum_q   <= sum_d;
			base_q  <= base_d;
			high_q  <= high_d;
			err_q   <= err_d;
		end
	end

endmodule

[hw/rtl/srlp_out_buf.sv]
// ----------------------------------------------------------------------------
// S-record line parser result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module srlp_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  srlp_pkg::out_item_t load_item,
	output logic                free,
	output logic                result_valid,
	input  logic                result_ready,
	output srlp_pkg::out_item_t result
);

	logic                valid_q;
	srlp_pkg::out_item_t item_q;

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			item_q <= load_item;
		end
	end

endmodule

[hw/rtl/srecord_line_parser_core.sv]
// ----------------------------------------------------------------------------
// S-record line parser core
// Input item register, parse step and result register.
//
// Characters of one S-record line enter on the item channel, one per item,
// and a separate item with line_end set closes the line. Each data byte of
// a type 1, 2 or 3 record leaves on the result channel with its address as
// soon as its second hex digit is taken; the line end item yields one
// status result (ok, not applicable, bad record). Other characters yield
// no result. An accepted item is held in the input register, and the parse
// step loads its result into the result register once that register is free.
// The block takes one item per cycle, bounded only by the result register
// draining. When the receiver stalls, the result register and the input
// register fill and item_ready drops until the receiver takes the waiting
// result. Reset clears all line state and empties both registers.
// ----------------------------------------------------------------------------
`include "srecord_line_parser_core_assert.svh"

module srecord_line_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  srlp_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output srlp_pkg::out_item_t result
);

	logic                valid_s1;
	srlp_pkg::in_item_t  item_s1;
	logic                out_free;
	logic                fire;
	logic                has_result;
	srlp_pkg::out_item_t step_result;

	assign fire       = valid_s1 && out_free;
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	srlp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire),
		.item       (item_s1),
		.has_result (has_result),
		.result     (step_result)
	);

	srlp_out_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && has_result),
		.load_item    (step_result),
		.free         (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`SRLP_ASSERT(a_s1_holds, valid_s1 && !fire |=> valid_s1, "Input item lost while stalled.")
	`SRLP_ASSERT(a_status_clean,
		result_valid && result.result_kind == srlp_pkg::KIND_STATUS
		|-> result.byte_address == 32'd0 && result.data_byte == 8'd0,
		"Status item carries data.")
	`SRLP_ASSERT_NEVER(a_data_status,
		result_valid && result.result_kind == srlp_pkg::KIND_DATA
		&& result.line_status != srlp_pkg::STATUS_OK,
		"Data item carries a status.")
	`SRLP_ASSERT(a_eol_result, fire && item_s1.line_end |-> has_result, "Line end without status.")

endmodule
